// ----- rtl/rtpf_pkg.sv -----
// rtpf_pkg: shared constants, codes and types for the two-plane rectangle fill core.
// No dependencies.
package rtpf_pkg;

  localparam int PANEL_WIDTH_DEF = 128;
  localparam int PLANE_BYTES_DEF = 4736;

  localparam logic [1:0] FN_RECT   = 2'd0;
  localparam logic [1:0] FN_SCREEN = 2'd1;
  localparam logic [1:0] FN_READ   = 2'd2;

  localparam logic [1:0] COL_BLACK = 2'd0;
  localparam logic [1:0] COL_WHITE = 2'd1;
  localparam logic [1:0] COL_RED   = 2'd2;
  localparam logic [1:0] COL_BAD   = 2'd3;

  localparam logic ST_DONE      = 1'b0;
  localparam logic ST_BAD_COLOR = 1'b1;

  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZEROS = 8'h00;

  // plane write request, shared by both planes at one address
  typedef struct packed {
    logic       en;
    logic [7:0] bw;
    logic [7:0] rd;
  } rtpf_wr_t;

endpackage

// ----- rtl/rtpf_ram.sv -----
// rtpf_ram: generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module rtpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4736
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rtpf_seq.sv -----
// rtpf_seq: request sequencer; walks rows and bytes with read-modify-write, fills, reads.
// Depends on rtpf_pkg.
module rtpf_seq #(
  parameter int PANEL_WIDTH = rtpf_pkg::PANEL_WIDTH_DEF,
  parameter int PLANE_BYTES = rtpf_pkg::PLANE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_func,
  input  logic [8:0]                     in_x_start,
  input  logic [8:0]                     in_x_end,
  input  logic [8:0]                     in_y_start,
  input  logic [8:0]                     in_y_end,
  input  logic [1:0]                     in_color,
  input  logic [12:0]                    in_byte_index,
  output logic [$clog2(PLANE_BYTES)-1:0] mem_addr,
  output rtpf_pkg::rtpf_wr_t             mem_wr,
  input  logic [7:0]                     mem_bw,
  input  logic [7:0]                     mem_rd,
  output logic                           out_valid,
  output logic [7:0]                     out_bw_byte,
  output logic [7:0]                     out_red_byte,
  output logic                           out_status
);

  localparam int AW    = $clog2(PLANE_BYTES);
  localparam int TOTAL = PLANE_BYTES * 8;
  localparam int ROWS  = (TOTAL + PANEL_WIDTH - 1) / PANEL_WIDTH;
  localparam int PIX_W = $clog2(512 * PANEL_WIDTH + TOTAL + 1024);
  localparam int XW    = $clog2(PANEL_WIDTH + 1);

  typedef enum logic [3:0] {
    S_FILL, S_IDLE, S_SETUP, S_ROW_A, S_ROW_B, S_BYTE_RD, S_BYTE_WR, S_READ_A, S_READ_B
  } state_t;

  state_t           state_r;
  logic             clearing_r;
  logic [AW-1:0]    addr_r;
  logic [AW-1:0]    bend_r;
  logic [8:0]       sx_r;
  logic [XW-1:0]    exc_r;
  logic [8:0]       eyc_r;
  logic [8:0]       y_r;
  logic [PIX_W-1:0] row_base_r;
  logic [PIX_W-1:0] ps_r;
  logic [PIX_W-1:0] pe_r;
  logic [2:0]       ps_lo_r;
  logic [2:0]       pe_lo_r;
  logic             first_r;
  logic [7:0]       mask_r;
  logic [7:0]       fill_bw_r;
  logic [7:0]       fill_rd_r;
  logic             out_valid_r;
  logic [7:0]       out_bw_r;
  logic [7:0]       out_rd_r;
  logic             out_status_r;

  logic [PIX_W-1:0] pe_c;
  logic [PIX_W-1:0] pe1;
  logic [2:0]       lo;
  logic [2:0]       hi;
  logic [7:0]       mask;
  logic             last_row;
  logic             last_byte;
  logic             col_bw;
  logic             col_rd;

  always_comb begin
    pe_c = (pe_r > PIX_W'(TOTAL)) ? PIX_W'(TOTAL) : pe_r;
    pe1  = pe_c - PIX_W'(1);
    lo   = first_r ? ps_lo_r : 3'd0;
    hi   = (addr_r == bend_r) ? pe_lo_r : 3'd7;
    for (int j = 0; j < 8; j++) begin
      mask[7 - j] = (3'(j) >= lo) && (3'(j) <= hi);
    end
    last_row  = (10'(y_r) + 10'd1) == 10'(eyc_r);
    last_byte = (addr_r == bend_r);
    col_bw    = (in_color == rtpf_pkg::COL_WHITE);
    col_rd    = (in_color != rtpf_pkg::COL_RED);
  end

  always_comb begin
    mem_wr.en = 1'b0;
    mem_wr.bw = fill_bw_r;
    mem_wr.rd = fill_rd_r;
    case (state_r)
      S_FILL: begin
        mem_wr.en = 1'b1;
      end
      S_BYTE_WR: begin
        mem_wr.en = 1'b1;
        mem_wr.bw = (mem_bw & ~mask_r) | (fill_bw_r & mask_r);
        mem_wr.rd = (mem_rd & ~mask_r) | (fill_rd_r & mask_r);
      end
      default: begin
        mem_wr.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      clearing_r  <= 1'b1;
      addr_r      <= '0;
      fill_bw_r   <= rtpf_pkg::BYTE_ZEROS;
      fill_rd_r   <= rtpf_pkg::BYTE_ZEROS;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            out_bw_r     <= rtpf_pkg::BYTE_ZEROS;
            out_rd_r     <= rtpf_pkg::BYTE_ZEROS;
            out_status_r <= rtpf_pkg::ST_DONE;
            if (in_func == rtpf_pkg::FN_READ) begin
              if (32'(in_byte_index) < 32'(PLANE_BYTES)) begin
                addr_r  <= AW'(in_byte_index);
                state_r <= S_READ_A;
              end else begin
                out_valid_r <= 1'b1;
              end
            end else if (in_func == rtpf_pkg::FN_RECT || in_func == rtpf_pkg::FN_SCREEN) begin
              if (in_color == rtpf_pkg::COL_BAD) begin
                out_status_r <= rtpf_pkg::ST_BAD_COLOR;
                out_valid_r  <= 1'b1;
              end else begin
                fill_bw_r <= col_bw ? rtpf_pkg::BYTE_ONES : rtpf_pkg::BYTE_ZEROS;
                fill_rd_r <= col_rd ? rtpf_pkg::BYTE_ONES : rtpf_pkg::BYTE_ZEROS;
                if (in_func == rtpf_pkg::FN_SCREEN) begin
                  addr_r     <= '0;
                  clearing_r <= 1'b0;
                  state_r    <= S_FILL;
                end else begin
                  sx_r       <= in_x_start;
                  exc_r      <= (32'(in_x_end) > 32'(PANEL_WIDTH)) ?
                                XW'(PANEL_WIDTH) : XW'(in_x_end);
                  eyc_r      <= (32'(in_y_end) > 32'(ROWS)) ? 9'(ROWS) : in_y_end;
                  y_r        <= in_y_start;
                  row_base_r <= PIX_W'(in_y_start) * PIX_W'(PANEL_WIDTH);
                  state_r    <= S_SETUP;
                end
              end
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        S_SETUP: begin
          if (16'(sx_r) >= 16'(exc_r) || y_r >= eyc_r) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_ROW_A;
          end
        end
        S_ROW_A: begin
          ps_r    <= row_base_r + PIX_W'(sx_r);
          pe_r    <= row_base_r + PIX_W'(exc_r);
          state_r <= S_ROW_B;
        end
        S_ROW_B: begin
          if (ps_r >= pe_c) begin
            row_base_r <= row_base_r + PIX_W'(PANEL_WIDTH);
            y_r        <= y_r + 9'd1;
            if (last_row) begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_ROW_A;
            end
          end else begin
            addr_r  <= ps_r[AW+2:3];
            bend_r  <= pe1[AW+2:3];
            ps_lo_r <= ps_r[2:0];
            pe_lo_r <= pe1[2:0];
            first_r <= 1'b1;
            state_r <= S_BYTE_RD;
          end
        end
        S_BYTE_RD: begin
          mask_r  <= mask;
          state_r <= S_BYTE_WR;
        end
        S_BYTE_WR: begin
          first_r <= 1'b0;
          if (last_byte) begin
            row_base_r <= row_base_r + PIX_W'(PANEL_WIDTH);
            y_r        <= y_r + 9'd1;
            if (last_row) begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_ROW_A;
            end
          end else begin
            addr_r  <= addr_r + AW'(1);
            state_r <= S_BYTE_RD;
          end
        end
        S_FILL: begin
          addr_r <= addr_r + AW'(1);
          if (addr_r == AW'(PLANE_BYTES - 1)) begin
            out_valid_r <= !clearing_r;
            clearing_r  <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_READ_A: begin
          state_r <= S_READ_B;
        end
        S_READ_B: begin
          out_bw_r    <= mem_bw;
          out_rd_r    <= mem_rd;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign mem_addr     = addr_r;
  assign out_valid    = out_valid_r;
  assign out_bw_byte  = out_bw_r;
  assign out_red_byte = out_rd_r;
  assign out_status   = out_status_r;

endmodule

// ----- rtl/two_plane_rect_fill_core.sv -----
// two_plane_rect_fill_core: top level; sequencer plus the black/white and red plane RAMs.
// Depends on rtpf_pkg, rtpf_ram, rtpf_seq.
//
// Frame store for a three-colour e-paper panel: two 1-bit planes, MSB-first, row-major.
// A request is taken when start is high and busy is low; its single result is shown on
// the out_ ports for one cycle with out_valid and cannot be held off by the receiver.
// After reset the block runs a clearing pass over every plane byte with busy high.
// A read returns both planes' byte at in_byte_index (zeros when out of range); a bad
// colour or unused code gets a result without touching the planes; a fill-screen
// writes every plane byte. A fill-rectangle walks each row and each plane byte touched,
// a read-modify-write through the single address port shared by both plane RAMs.
module two_plane_rect_fill_core #(
  parameter int PANEL_WIDTH = rtpf_pkg::PANEL_WIDTH_DEF,
  parameter int PLANE_BYTES = rtpf_pkg::PLANE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [8:0]  in_x_start,
  input  logic [8:0]  in_x_end,
  input  logic [8:0]  in_y_start,
  input  logic [8:0]  in_y_end,
  input  logic [1:0]  in_color,
  input  logic [12:0] in_byte_index,
  output logic        out_valid,
  output logic [7:0]  out_bw_byte,
  output logic [7:0]  out_red_byte,
  output logic        out_status
);

  localparam int AW = $clog2(PLANE_BYTES);

  logic [AW-1:0]      mem_addr;
  rtpf_pkg::rtpf_wr_t mem_wr;
  logic [7:0]         mem_bw;
  logic [7:0]         mem_rd;

  rtpf_seq #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PLANE_BYTES (PLANE_BYTES)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_x_start    (in_x_start),
    .in_x_end      (in_x_end),
    .in_y_start    (in_y_start),
    .in_y_end      (in_y_end),
    .in_color      (in_color),
    .in_byte_index (in_byte_index),
    .mem_addr      (mem_addr),
    .mem_wr        (mem_wr),
    .mem_bw        (mem_bw),
    .mem_rd        (mem_rd),
    .out_valid     (out_valid),
    .out_bw_byte   (out_bw_byte),
    .out_red_byte  (out_red_byte),
    .out_status    (out_status)
  );

  rtpf_ram #(
    .WIDTH (8),
    .DEPTH (PLANE_BYTES)
  ) u_bw_plane (
    .clk   (clk),
    .we    (mem_wr.en),
    .waddr (mem_addr),
    .wdata (mem_wr.bw),
    .raddr (mem_addr),
    .rdata (mem_bw)
  );

  rtpf_ram #(
    .WIDTH (8),
    .DEPTH (PLANE_BYTES)
  ) u_red_plane (
    .clk   (clk),
    .we    (mem_wr.en),
    .waddr (mem_addr),
    .wdata (mem_wr.rd),
    .raddr (mem_addr),
    .rdata (mem_rd)
  );

endmodule

// ----- rtl/rtpf_chk.sv -----
// rtpf_chk: port-level checks on the fill core, bound to two_plane_rect_fill_core.
// Depends on rtpf_pkg.
module rtpf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_func,
  input logic [1:0]  in_color,
  input logic        out_valid,
  input logic [7:0]  out_bw_byte,
  input logic [7:0]  out_red_byte,
  input logic        out_status
);

  logic take;
  logic is_fill;

  assign take    = start && !busy;
  assign is_fill = (in_func == rtpf_pkg::FN_RECT) || (in_func == rtpf_pkg::FN_SCREEN);

  a_bad_color: assert property (@(posedge clk) disable iff (!rst_n)
    take && is_fill && in_color == rtpf_pkg::COL_BAD
    |=> out_valid && out_status == rtpf_pkg::ST_BAD_COLOR)
    else $error("bad colour request not rejected at once");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rtpf_pkg::ST_BAD_COLOR
    |-> out_bw_byte == 8'h00 && out_red_byte == 8'h00)
    else $error("error result carries plane data");

  a_good_fill_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take && is_fill && in_color != rtpf_pkg::COL_BAD |=> busy && !out_valid)
    else $error("fill finished without walking the store");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

endmodule

bind two_plane_rect_fill_core rtpf_chk u_rtpf_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_func      (in_func),
  .in_color     (in_color),
  .out_valid    (out_valid),
  .out_bw_byte  (out_bw_byte),
  .out_red_byte (out_red_byte),
  .out_status   (out_status)
);
